>>> rtl/core/abfm_pkg.sv
// abfm_pkg: shared types, codes and helpers of the acceleration / brake fault monitor
`default_nettype none

package abfm_pkg;

  // input operation codes
  localparam logic [1:0] OP_MEAS  = 2'd0;
  localparam logic [1:0] OP_CMD   = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_MS         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_FLOOR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_CEILING   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHECK_SPEED = 3'd4;

  // verdict codes
  typedef enum logic [1:0] {
    VERDICT_OK    = 2'd0,
    VERDICT_BRAKE = 2'd1,
    VERDICT_ACCEL = 2'd2
  } verdict_e;

  // commands to one window
  typedef enum logic [1:0] {
    WIN_NOP    = 2'd0,
    WIN_CLEAR  = 2'd1,
    WIN_APPEND = 2'd2,
    WIN_SCAN   = 2'd3
  } win_cmd_e;

  // one stored sample
  typedef struct packed {
    logic        [31:0] stamp;
    logic signed [15:0] value;
  } entry_t;

  // request to a window
  typedef struct packed {
    win_cmd_e           cmd;
    logic        [31:0] now;
    logic        [31:0] stamp;
    logic signed [15:0] value;
  } win_req_t;

  // response from a window; spans and extremes hold until the next scan
  typedef struct packed {
    logic               done;
    logic               spans;
    logic signed [15:0] vmin;
    logic signed [15:0] vmax;
  } win_rsp_t;

  // stamp older than the span, with a signed wrapping age
  function automatic logic aged_past(input logic [31:0] now, input logic [31:0] stamp,
                                     input logic [15:0] span);
    logic [31:0] age;
    age = now - stamp;
    return !age[31] && (age > {16'b0, span});
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/abfm_window.sv
// abfm_window: one circular sample window in a synchronous memory with append, clear and scan
`default_nettype none

module abfm_window #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [15:0]       span_ms_i,
  input  wire abfm_pkg::win_req_t req_i,
  output abfm_pkg::win_rsp_t     rsp_o
);
  import abfm_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [4:0] {
    W_IDLE     = 5'b00001,
    W_APP_RD   = 5'b00010,
    W_APP_CHK  = 5'b00100,
    W_SCAN     = 5'b01000,
    W_SCAN_END = 5'b10000
  } wstate_e;

  wstate_e       state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          done_q, done_d;
  logic          scan_rd_q;
  logic          first_q, first_d;

  logic [31:0]        now_q;
  logic               spans_q;
  logic signed [15:0] min_q, max_q;

  entry_t        mem_q [WINDOW_DEPTH];
  entry_t        rdata_q;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;

  logic [AW-1:0] h1;
  logic [CW-1:0] c1;
  logic [AW:0]   slot_sum;
  logic          full;

  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
    return (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // append slot after dropping the oldest of a full window
  always_comb begin
    full     = (count_q == CW'(WINDOW_DEPTH));
    h1       = full ? inc_ptr(head_q) : head_q;
    c1       = full ? count_q : count_q + 1'b1;
    slot_sum = {1'b0, h1} + {1'b0, AW'(c1 - 1'b1)};
    if (slot_sum >= (AW+1)'(WINDOW_DEPTH)) begin
      slot_sum = slot_sum - (AW+1)'(WINDOW_DEPTH);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    idx_d   = idx_q;
    done_d  = 1'b0;
    first_d = first_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = slot_sum[AW-1:0];
    raddr   = ptr_q;
    case (state_q)
      W_IDLE: begin
        case (req_i.cmd)
          WIN_CLEAR: begin
            head_d  = '0;
            count_d = '0;
            done_d  = 1'b1;
          end
          WIN_APPEND: begin
            we      = 1'b1;
            head_d  = h1;
            count_d = c1;
            if (c1 >= CW'(2)) begin
              state_d = W_APP_RD;
            end else begin
              done_d = 1'b1;
            end
          end
          WIN_SCAN: begin
            ptr_d   = head_q;
            idx_d   = '0;
            first_d = 1'b1;
            if (count_q == '0) begin
              done_d = 1'b1;
            end else begin
              state_d = W_SCAN;
            end
          end
          default: ;
        endcase
      end
      W_APP_RD: begin
        re      = 1'b1;
        raddr   = inc_ptr(head_q);
        state_d = W_APP_CHK;
      end
      W_APP_CHK: begin
        if (aged_past(now_q, rdata_q.stamp, span_ms_i)) begin
          head_d  = inc_ptr(head_q);
          count_d = count_q - 1'b1;
        end
        done_d  = 1'b1;
        state_d = W_IDLE;
      end
      W_SCAN: begin
        re    = 1'b1;
        ptr_d = inc_ptr(ptr_q);
        idx_d = idx_q + 1'b1;
        if (idx_q == count_q - 1'b1) begin
          state_d = W_SCAN_END;
        end
      end
      W_SCAN_END: begin
        done_d  = 1'b1;
        state_d = W_IDLE;
      end
      default: state_d = W_IDLE;
    endcase
    // the first word of a scan is the oldest entry
    if (scan_rd_q) begin
      first_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= W_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      ptr_q     <= '0;
      idx_q     <= '0;
      done_q    <= 1'b0;
      scan_rd_q <= 1'b0;
      first_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      idx_q     <= idx_d;
      done_q    <= done_d;
      scan_rd_q <= (state_q == W_SCAN);
      first_q   <= first_d;
    end
  end

  // captured time and running extremes
  always_ff @(posedge clk_i) begin
    if (state_q == W_IDLE && req_i.cmd != WIN_NOP) begin
      now_q <= req_i.now;
    end
    if (state_q == W_IDLE && req_i.cmd == WIN_SCAN) begin
      spans_q <= 1'b0;
    end
    if (scan_rd_q) begin
      if (first_q) begin
        spans_q <= aged_past(now_q, rdata_q.stamp, span_ms_i);
        min_q   <= rdata_q.value;
        max_q   <= rdata_q.value;
      end else begin
        if (rdata_q.value < min_q) min_q <= rdata_q.value;
        if (rdata_q.value > max_q) max_q <= rdata_q.value;
      end
    end
  end

  // sample memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= '{stamp: req_i.stamp, value: req_i.value};
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign rsp_o = '{done: done_q, spans: spans_q, vmin: min_q, vmax: max_q};

endmodule

`default_nettype wire

>>> rtl/core/accel_brake_fault_monitor_top.sv
// accel_brake_fault_monitor_top: command port, configuration registers and verdict logic
// A sample word appends to or clears its window; when the window holds two or more entries
// after append, it reads the next-oldest entry and drops the oldest if that one is aged.
// A check with the gate closed gives its result without a scan; an open check scans both
// windows, one entry a cycle. One word in work at a time; results cannot be held off.
// Reset clears head and count of both windows and loads the register defaults.
`default_nettype none

module accel_brake_fault_monitor_top #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cfg_we_i,
  input  wire logic [abfm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                   cfg_wdata_i,
  input  wire logic [1:0]                    op_i,
  input  wire logic [31:0]                   now_time_i,
  input  wire logic [31:0]                   sample_stamp_i,
  input  wire logic signed [15:0]            sample_value_i,
  input  wire logic                          reports_ready_i,
  input  wire logic                          auto_enabled_i,
  input  wire logic signed [16:0]            forward_speed_i,
  output logic                               result_valid_o,
  output logic [1:0]                         verdict_o,
  output logic                               windows_filled_o
);
  import abfm_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE   = 3'b001,
    T_SAMPLE = 3'b010,
    T_CHECK  = 3'b100
  } tstate_e;

  tstate_e state_q, state_d;
  logic    sel_cmd_q, sel_cmd_d;
  logic    dm_q, dm_d, dc_q, dc_d;
  logic    valid_q, valid_d;
  logic [1:0] verdict_q, verdict_d;
  logic    filled_q, filled_d;

  logic [15:0]        span_ms_q;
  logic [14:0]        diff_thresh_q;
  logic signed [15:0] decel_floor_q;
  logic [14:0]        accel_ceiling_q;
  logic [15:0]        min_check_speed_q;

  win_req_t req_m, req_c;
  win_rsp_t rsp_m, rsp_c;

  logic accept, gate, speed_ok;
  logic signed [15:0] cmd_max_c, cmd_min_c, ceil_s;
  logic signed [16:0] brake_diff, accel_diff, th_s, neg_th;
  verdict_e           verdict_calc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_ms_q         <= 16'd1000;
      diff_thresh_q     <= 15'd1000;
      decel_floor_q     <= -16'sd3000;
      accel_ceiling_q   <= 15'd3000;
      min_check_speed_q <= 16'd1390;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SPAN_MS:         span_ms_q         <= cfg_wdata_i;
        REG_DIFF_THRESH:     diff_thresh_q     <= cfg_wdata_i[14:0];
        REG_DECEL_FLOOR:     decel_floor_q     <= $signed(cfg_wdata_i);
        REG_ACCEL_CEILING:   accel_ceiling_q   <= cfg_wdata_i[14:0];
        REG_MIN_CHECK_SPEED: min_check_speed_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // gate on the incoming word
  assign accept   = start && !busy;
  assign gate     = reports_ready_i && auto_enabled_i;
  assign speed_ok = forward_speed_i >= $signed({1'b0, min_check_speed_q});

  // requests to the two windows
  always_comb begin
    req_m = '{cmd: WIN_NOP, now: now_time_i, stamp: sample_stamp_i, value: sample_value_i};
    req_c = req_m;
    if (accept) begin
      case (op_i)
        OP_MEAS:  req_m.cmd = (gate && speed_ok) ? WIN_APPEND : WIN_CLEAR;
        OP_CMD:   req_c.cmd = (gate && speed_ok) ? WIN_APPEND : WIN_CLEAR;
        OP_CHECK: begin
          if (gate) begin
            req_m.cmd = WIN_SCAN;
            req_c.cmd = WIN_SCAN;
          end
        end
        default: ;
      endcase
    end
  end

  abfm_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_meas (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .span_ms_i (span_ms_q),
    .req_i     (req_m),
    .rsp_o     (rsp_m)
  );

  abfm_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_cmd (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .span_ms_i (span_ms_q),
    .req_i     (req_c),
    .rsp_o     (rsp_c)
  );

  // clamped extremes against the threshold
  always_comb begin
    ceil_s     = $signed({1'b0, accel_ceiling_q});
    cmd_max_c  = (rsp_c.vmax < decel_floor_q) ? decel_floor_q : rsp_c.vmax;
    cmd_min_c  = (rsp_c.vmin > ceil_s) ? ceil_s : rsp_c.vmin;
    th_s       = $signed({2'b00, diff_thresh_q});
    neg_th     = -th_s;
    brake_diff = 17'(cmd_max_c) - 17'(rsp_m.vmin);
    accel_diff = 17'(cmd_min_c) - 17'(rsp_m.vmax);
    if (!(rsp_m.spans && rsp_c.spans)) begin
      verdict_calc = VERDICT_OK;
    end else if (cmd_max_c[15] && (brake_diff < neg_th)) begin
      verdict_calc = VERDICT_BRAKE;
    end else if ((cmd_min_c > 16'sd0) && (accel_diff > th_s)) begin
      verdict_calc = VERDICT_ACCEL;
    end else begin
      verdict_calc = VERDICT_OK;
    end
  end

  // word sequencing
  always_comb begin
    state_d   = state_q;
    sel_cmd_d = sel_cmd_q;
    dm_d      = dm_q;
    dc_d      = dc_q;
    valid_d   = 1'b0;
    verdict_d = verdict_q;
    filled_d  = filled_q;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_MEAS, OP_CMD: begin
              sel_cmd_d = (op_i == OP_CMD);
              state_d   = T_SAMPLE;
            end
            OP_CHECK: begin
              if (gate) begin
                dm_d    = 1'b0;
                dc_d    = 1'b0;
                state_d = T_CHECK;
              end else begin
                valid_d   = 1'b1;
                verdict_d = VERDICT_OK;
                filled_d  = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      T_SAMPLE: begin
        if (sel_cmd_q ? rsp_c.done : rsp_m.done) begin
          state_d = T_IDLE;
        end
      end
      T_CHECK: begin
        dm_d = dm_q || rsp_m.done;
        dc_d = dc_q || rsp_c.done;
        if (dm_d && dc_d) begin
          valid_d   = 1'b1;
          verdict_d = verdict_calc;
          filled_d  = rsp_m.spans && rsp_c.spans;
          state_d   = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      sel_cmd_q <= 1'b0;
      dm_q      <= 1'b0;
      dc_q      <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      sel_cmd_q <= sel_cmd_d;
      dm_q      <= dm_d;
      dc_q      <= dc_d;
      valid_q   <= valid_d;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    filled_q  <= filled_d;
  end

  assign busy             = (state_q != T_IDLE);
  assign result_valid_o   = valid_q;
  assign verdict_o        = verdict_q;
  assign windows_filled_o = filled_q;

endmodule

`default_nettype wire

>>> bench/accel_brake_fault_monitor_top_tb.sv
// testbench for the acceleration / brake fault monitor: directed and random words, self-checked
module accel_brake_fault_monitor_top_tb;
  import abfm_pkg::*;

  localparam int          WIN_DEPTH     = 64;
  localparam int          MEAS_WIN      = 0;
  localparam int          CMD_WIN       = 1;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int unsigned TOTAL_WORDS   = 1550;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 2 * WIN_DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  // one command word as driven on the ports
  typedef struct {
    logic [1:0]         op;
    logic [31:0]        now;
    logic [31:0]        stamp;
    logic signed [15:0] value;
    logic               ready;
    logic               enabled;
    logic signed [16:0] speed;
  } word_t;

  // verdict expected from one check
  typedef struct {
    verdict_e verdict;
    logic     filled;
  } check_outcome_t;

  // own model of both windows and the registers, plus the verdicts still owed
  class verdict_scoreboard;
    logic [31:0]        win_stamp [2][WIN_DEPTH];
    logic signed [15:0] win_value [2][WIN_DEPTH];
    int unsigned        win_head  [2];
    int unsigned        win_count [2];
    logic [15:0]        span_ms;
    logic [14:0]        diff_thresh;
    logic signed [15:0] decel_floor;
    logic [14:0]        accel_ceiling;
    logic [15:0]        min_check_speed;
    check_outcome_t     pending_verdicts [$];
    int unsigned        errors;

    function new();
      win_head        = '{0, 0};
      win_count       = '{0, 0};
      span_ms         = 16'd1000;
      diff_thresh     = 15'd1000;
      decel_floor     = -16'sd3000;
      accel_ceiling   = 15'd3000;
      min_check_speed = 16'd1390;
      errors          = 0;
    endfunction

    // registers keep only their own width
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        REG_SPAN_MS:         span_ms         = data;
        REG_DIFF_THRESH:     diff_thresh     = data[14:0];
        REG_DECEL_FLOOR:     decel_floor     = data;
        REG_ACCEL_CEILING:   accel_ceiling   = data[14:0];
        REG_MIN_CHECK_SPEED: min_check_speed = data;
        default: ;
      endcase
    endfunction

    // signed wrapping age, strictly older than the span
    function bit is_stale(logic [31:0] now, logic [31:0] stamp);
      logic [31:0] age;
      age = now - stamp;
      return !age[31] && (age > {16'd0, span_ms});
    endfunction

    function void drop_oldest(int w);
      if (win_count[w] == 0) return;
      win_head[w] = (win_head[w] + 1) % WIN_DEPTH;
      win_count[w]--;
    endfunction

    function bit spans(int w, logic [31:0] now);
      if (win_count[w] == 0) return 1'b0;
      return is_stale(now, win_stamp[w][win_head[w]]);
    endfunction

    function void extremes(int w, output int lo, output int hi);
      int v;
      lo = 0;
      hi = 0;
      for (int unsigned i = 0; i < win_count[w]; i++) begin
        v = win_value[w][(win_head[w] + i) % WIN_DEPTH];
        if (i == 0 || v < lo) lo = v;
        if (i == 0 || v > hi) hi = v;
      end
    endfunction

    // update the windows for an accepted word; a check owes one verdict
    function void note_word(word_t wd);
      int             w;
      int             speed_mm;
      int unsigned    slot;
      int             meas_min, meas_max, cmd_min, cmd_max, th;
      bit             gate;
      check_outcome_t outcome;
      gate     = wd.ready && wd.enabled;
      speed_mm = wd.speed;
      case (wd.op)
        OP_MEAS, OP_CMD: begin
          w = (wd.op == OP_MEAS) ? MEAS_WIN : CMD_WIN;
          if (!gate || speed_mm < int'(min_check_speed)) begin
            win_head[w]  = 0;
            win_count[w] = 0;
          end else begin
            if (win_count[w] >= WIN_DEPTH) drop_oldest(w);
            slot = (win_head[w] + win_count[w]) % WIN_DEPTH;
            win_stamp[w][slot] = wd.stamp;
            win_value[w][slot] = wd.value;
            win_count[w]++;
            if (win_count[w] >= 2 &&
                is_stale(wd.now, win_stamp[w][(win_head[w] + 1) % WIN_DEPTH]))
              drop_oldest(w);
          end
        end
        OP_CHECK: begin
          outcome.verdict = VERDICT_OK;
          outcome.filled  = 1'b0;
          if (gate && spans(MEAS_WIN, wd.now) && spans(CMD_WIN, wd.now)) begin
            outcome.filled = 1'b1;
            th = diff_thresh;
            extremes(MEAS_WIN, meas_min, meas_max);
            extremes(CMD_WIN, cmd_min, cmd_max);
            if (cmd_max < int'(decel_floor)) cmd_max = decel_floor;
            if (cmd_min > int'(accel_ceiling)) cmd_min = accel_ceiling;
            if (cmd_max < 0 && cmd_max - meas_min < -th)
              outcome.verdict = VERDICT_BRAKE;
            else if (cmd_min > 0 && cmd_min - meas_max > th)
              outcome.verdict = VERDICT_ACCEL;
          end
          pending_verdicts.push_back(outcome);
        end
        default: ;
      endcase
    endfunction

    // compare a result word with the oldest owed verdict
    function void check_verdict(logic [1:0] got_verdict, logic got_filled);
      check_outcome_t want;
      if (pending_verdicts.size() == 0) begin
        $error("verdict word with no check pending: verdict %0d filled %0d",
               got_verdict, got_filled);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got_verdict !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, got_verdict);
        errors++;
      end
      if (got_filled !== want.filled) begin
        $error("windows_filled: expected %0d, got %0d", want.filled, got_filled);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [15:0]             cfg_wdata_i;
  logic [1:0]              op_i;
  logic [31:0]             now_time_i;
  logic [31:0]             sample_stamp_i;
  logic signed [15:0]      sample_value_i;
  logic                    reports_ready_i;
  logic                    auto_enabled_i;
  logic signed [16:0]      forward_speed_i;
  logic                    result_valid_o;
  logic [1:0]              verdict_o;
  logic                    windows_filled_o;

  verdict_scoreboard sb;
  int unsigned       words_sent = 0;
  int unsigned       cycle_count = 0;
  logic [31:0]       clock_ms = 32'd7000;

  accel_brake_fault_monitor_top #(
    .WINDOW_DEPTH(WIN_DEPTH)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (op_i),
    .now_time_i       (now_time_i),
    .sample_stamp_i   (sample_stamp_i),
    .sample_value_i   (sample_value_i),
    .reports_ready_i  (reports_ready_i),
    .auto_enabled_i   (auto_enabled_i),
    .forward_speed_i  (forward_speed_i),
    .result_valid_o   (result_valid_o),
    .verdict_o        (verdict_o),
    .windows_filled_o (windows_filled_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** accel_brake_fault_monitor_top: FAILED **");
      $finish;
    end
  end

  // result words are one-cycle strobes, sampled at the closing edge
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_verdict(verdict_o, windows_filled_o);
  end

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic word_t mk_word(input logic [1:0] op, input logic [31:0] now,
                                    input logic [31:0] stamp, input logic signed [15:0] value,
                                    input logic ready, input logic enabled,
                                    input logic signed [16:0] speed);
    word_t wd;
    wd.op      = op;
    wd.now     = now;
    wd.stamp   = stamp;
    wd.value   = value;
    wd.ready   = ready;
    wd.enabled = enabled;
    wd.speed   = speed;
    return wd;
  endfunction

  // present a word after an optional gap, hold start until busy is low at an edge
  task automatic send_word(input word_t wd, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_i            <= wd.op;
    now_time_i      <= wd.now;
    sample_stamp_i  <= wd.stamp;
    sample_value_i  <= wd.value;
    reports_ready_i <= wd.ready;
    auto_enabled_i  <= wd.enabled;
    forward_speed_i <= wd.speed;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_word(wd);
    if (wd.op != OP_UNUSED) words_sent++;
  endtask

  // stop sending and wait for every owed verdict and the block to go idle
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_verdicts.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // write all five registers back to back, optionally poking an unused index too
  task automatic load_config(input logic [15:0] st, input logic [15:0] dt,
                             input logic [15:0] df, input logic [15:0] ac,
                             input logic [15:0] ms, input bit stray);
    cfg_we_i <= 1'b1;
    put_reg(REG_SPAN_MS, st);
    put_reg(REG_DIFF_THRESH, dt);
    put_reg(REG_DECEL_FLOOR, df);
    put_reg(REG_ACCEL_CEILING, ac);
    put_reg(REG_MIN_CHECK_SPEED, ms);
    if (stray) put_reg(CFG_IDX_W'(REG_MIN_CHECK_SPEED + 1 + $urandom_range(0, 2)),
                       16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // extremes, every op, closed gates, exact span boundary, wrap, brake and accel cases
  task automatic run_directed();
    send_word(mk_word(OP_CHECK, 0, 0, 0, 1, 1, 17'sd65535), 0);
    send_word(mk_word(OP_CHECK, 5000, 0, 0, 0, 1, 17'sd65535), 0);
    send_word(mk_word(OP_CHECK, 5000, 0, 0, 1, 0, 17'sd65535), 1);
    send_word(mk_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -16'sd1, 1, 1, -17'sd1), 0);
    send_word(mk_word(OP_MEAS, 0, 0, 0, 1, 1, 17'h10000), 0);
    send_word(mk_word(OP_MEAS, 0, 0, 0, 1, 1, 17'sd1389), 2);
    send_word(mk_word(OP_MEAS, 0, 0, 16'sh8000, 1, 1, 17'sd65535), 0);
    send_word(mk_word(OP_CMD, 0, 0, 16'sh7FFF, 1, 1, 17'sd1390), 0);
    send_word(mk_word(OP_MEAS, 1001, 1001, 16'sh7FFF, 1, 1, 17'sd3000), 0);
    send_word(mk_word(OP_CMD, 1001, 1001, 16'sh8000, 1, 1, 17'sd3000), 0);
    send_word(mk_word(OP_CHECK, 1001, 0, 0, 1, 1, 17'sd3000), 0);
    send_word(mk_word(OP_CHECK, 1000, 0, 0, 1, 1, 17'sd3000), 0);
    send_word(mk_word(OP_MEAS, 1100, 32'hFFFF_FFFF, 0, 1, 1, 17'sd3000), 3);
    send_word(mk_word(OP_CHECK, 32'h8000_0000, 0, 0, 1, 1, 17'sd3000), 0);
    send_word(mk_word(OP_CMD, 2000, 2000, 0, 1, 0, 17'sd3000), 0);
    send_word(mk_word(OP_CMD, 2000, 2000, -16'sd5000, 1, 1, 17'sd3000), 0);
    send_word(mk_word(OP_CMD, 3100, 3100, -16'sd4000, 1, 1, 17'sd3000), 0);
    send_word(mk_word(OP_MEAS, 3100, 3100, 0, 1, 1, 17'sd3000), 0);
    send_word(mk_word(OP_CHECK, 3100, 0, 0, 1, 1, 17'sd3000), 0);
    send_word(mk_word(OP_MEAS, 5000, 5000, 0, 0, 1, 17'sd3000), 0);
    send_word(mk_word(OP_CMD, 5000, 5000, 0, 0, 0, 17'sd3000), 0);
    send_word(mk_word(OP_MEAS, 5000, 5000, -16'sd100, 1, 1, 17'sd3000), 0);
    send_word(mk_word(OP_CMD, 5000, 5000, 16'sd4000, 1, 1, 17'sd3000), 0);
    send_word(mk_word(OP_MEAS, 6100, 6100, 0, 1, 1, 17'sd3000), 0);
    send_word(mk_word(OP_CMD, 6100, 6100, 16'sd5000, 1, 1, 17'sd3000), 0);
    send_word(mk_word(OP_CHECK, 6100, 0, 0, 1, 1, 17'sd3000), 0);
  endtask

  // a run of well-formed sample streams with random content, some checks, a little noise
  task automatic run_burst(input int unsigned n_words, input bit no_gaps);
    word_t       wd;
    int          cmd_base, meas_base, cmd_spread, meas_spread, th, base, spread;
    int unsigned step_ms, target, pick, gap;
    target  = words_sent + n_words;
    th      = sb.diff_thresh;
    step_ms = sb.span_ms / $urandom_range(4, 90) + $urandom_range(1, 25);
    case ($urandom_range(0, 4))
      0: clock_ms = $urandom;
      1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * step_ms + 1000);
      default: ;
    endcase
    // value profile: anything, brake-like, accel-like or quiet
    case ($urandom_range(0, 3))
      0: begin
        cmd_base    = int'($urandom_range(0, 65535)) - 32768;
        meas_base   = int'($urandom_range(0, 65535)) - 32768;
        cmd_spread  = $urandom_range(0, 32767);
        meas_spread = $urandom_range(0, 32767);
      end
      1: begin
        cmd_base    = -int'($urandom_range(1, 9000));
        meas_base   = cmd_base + th + int'($urandom_range(0, 4000)) - 2000;
        cmd_spread  = $urandom_range(0, 500);
        meas_spread = $urandom_range(0, 500);
      end
      2: begin
        cmd_base    = $urandom_range(1, 9000);
        meas_base   = cmd_base - th - int'($urandom_range(0, 4000)) + 2000;
        cmd_spread  = $urandom_range(0, 500);
        meas_spread = $urandom_range(0, 500);
      end
      default: begin
        cmd_base    = int'($urandom_range(0, 4000)) - 2000;
        meas_base   = cmd_base + int'($urandom_range(0, 600)) - 300;
        cmd_spread  = $urandom_range(0, 300);
        meas_spread = $urandom_range(0, 300);
      end
    endcase
    while (words_sent < target) begin
      pick  = $urandom_range(0, 99);
      wd.op = (pick < 42) ? OP_MEAS : (pick < 84) ? OP_CMD : OP_CHECK;
      if (wd.op != OP_CHECK) clock_ms += $urandom_range(0, step_ms);
      wd.now   = clock_ms;
      wd.stamp = ($urandom_range(0, 49) == 0) ? $urandom
                                               : clock_ms - $urandom_range(0, step_ms / 2);
      base     = (wd.op == OP_CMD) ? cmd_base : meas_base;
      spread   = (wd.op == OP_CMD) ? cmd_spread : meas_spread;
      wd.value   = clamp16(base + int'($urandom_range(0, 2 * spread)) - spread);
      wd.ready   = 1'b1;
      wd.enabled = 1'b1;
      wd.speed   = 17'($urandom_range(sb.min_check_speed, 65535));
      // noise: any op, closed gates, any speed
      if (pick >= 96) begin
        wd.op      = 2'($urandom_range(0, 3));
        wd.stamp   = $urandom;
        wd.ready   = 1'($urandom_range(0, 1));
        wd.enabled = 1'($urandom_range(0, 1));
        wd.speed   = 17'($urandom);
        if ($urandom_range(0, 3) == 0) wd.now = $urandom;
      end
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 60) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else if (pick < 98) gap = $urandom_range(4, 15);
      else gap = $urandom_range(16, 60);
      send_word(wd, gap);
    end
  endtask

  // main sequence
  initial begin
    int unsigned phase;
    int unsigned n_burst;
    sb              = new();
    rst_ni          = 1'b0;
    start           = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_wdata_i     = '0;
    op_i            = OP_MEAS;
    now_time_i      = '0;
    sample_stamp_i  = '0;
    sample_value_i  = '0;
    reports_ready_i = 1'b0;
    auto_enabled_i  = 1'b0;
    forward_speed_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_burst($urandom_range(120, 220), 1'b0);

    // register settings: low extremes, high extremes, then random
    phase = 0;
    while (words_sent < TOTAL_WORDS) begin
      settle();
      case (phase)
        0: load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        1: load_config(16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b0);
        default: load_config(16'($urandom_range(0, 6000)), 16'($urandom),
                             16'(-$urandom_range(0, 32768)), 16'($urandom),
                             16'($urandom_range(0, 4000)), phase == 2);
      endcase
      n_burst = $urandom_range(120, 220);
      if (n_burst > TOTAL_WORDS - words_sent) n_burst = TOTAL_WORDS - words_sent;
      run_burst(n_burst, $urandom_range(0, 3) == 0);
      phase++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** accel_brake_fault_monitor_top: PASSED **");
    end else begin
      $display("** accel_brake_fault_monitor_top: FAILED **");
    end
    $finish;
  end

endmodule
